// ===== design/dpb_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and codes of the depth-to-point back-projection block.
// Used by every module and interface of the block; depends on nothing.
package dpb_pkg;

    localparam int MAX_HALF_SIZE = 1024;

    localparam int HALF_W   = 11;
    localparam int FOCAL_W  = 24;
    localparam int DEPTH_W  = 16;
    localparam int CHAN_W   = 8;
    localparam int POS_W    = 36;
    localparam int Z_W      = 24;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 24;

    localparam int OFS_W    = HALF_W + 1;          // signed offset u or v
    localparam int PD_W     = HALF_W + DEPTH_W;    // |offset| * depth
    localparam int PF_W     = PD_W + FOCAL_W;      // |offset| * depth * inv_focal
    localparam int FRAC_SHIFT = 16;
    localparam int Q_W      = PF_W - FRAC_SHIFT;   // magnitude after the shift

    localparam logic [HALF_W-1:0] HALF_W_RESET = HALF_W'(320);
    localparam logic [HALF_W-1:0] HALF_H_RESET = HALF_W'(240);
    localparam logic [FOCAL_W-1:0] FOCAL_RESET = FOCAL_W'(31956);
    localparam logic [HALF_W-1:0] HALF_MAX = HALF_W'(MAX_HALF_SIZE);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HALF_WIDTH  = 2'd0,
        CFG_HALF_HEIGHT = 2'd1,
        CFG_INV_FOCAL   = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MULT_OFFSET,
        ST_MULT_FOCAL,
        ST_DELIVER
    } state_t;

    typedef struct packed {
        logic accept;
        logic step_offset;
        logic step_focal;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

    typedef struct packed {
        logic [DEPTH_W-1:0] depth_mm;
        logic [CHAN_W-1:0]  chan0;
        logic [CHAN_W-1:0]  chan1;
        logic [CHAN_W-1:0]  chan2;
    } pixel_t;

    typedef struct packed {
        logic signed [POS_W-1:0] x_pos;
        logic signed [POS_W-1:0] y_pos;
        logic [Z_W-1:0]          z_pos;
        logic                    point_valid;
        logic [CHAN_W-1:0]       out_chan0;
        logic [CHAN_W-1:0]       out_chan1;
        logic [CHAN_W-1:0]       out_chan2;
        logic                    frame_last;
    } point_t;

    // Clamp a half size to the range the counters support.
    function automatic logic [HALF_W-1:0] eff_half(input logic [HALF_W-1:0] h);
        logic [HALF_W-1:0] r;
        if (h == '0)
            r = HALF_W'(1);
        else if (h > HALF_MAX)
            r = HALF_MAX;
        else
            r = h;
        return r;
    endfunction

endpackage

// ===== design/dpb_pixel_if.sv =====
`timescale 1ns / 1ps
// Input pixel channel: valid/ready handshake with depth and colour payload.
// Depends on dpb_pkg for field widths.
interface dpb_pixel_if;
    logic                         valid;
    logic                         ready;
    logic [dpb_pkg::DEPTH_W-1:0]  depth_mm;
    logic [dpb_pkg::CHAN_W-1:0]   chan0;
    logic [dpb_pkg::CHAN_W-1:0]   chan1;
    logic [dpb_pkg::CHAN_W-1:0]   chan2;

    modport source (output valid, depth_mm, chan0, chan1, chan2, input ready);
    modport sink   (input valid, depth_mm, chan0, chan1, chan2, output ready);
endinterface

// ===== design/dpb_point_if.sv =====
`timescale 1ns / 1ps
// Output point channel: valid/ready handshake with coordinate and colour payload.
// Depends on dpb_pkg for field widths.
interface dpb_point_if;
    logic                              valid;
    logic                              ready;
    logic signed [dpb_pkg::POS_W-1:0]  x_pos;
    logic signed [dpb_pkg::POS_W-1:0]  y_pos;
    logic [dpb_pkg::Z_W-1:0]           z_pos;
    logic                              point_valid;
    logic [dpb_pkg::CHAN_W-1:0]        out_chan0;
    logic [dpb_pkg::CHAN_W-1:0]        out_chan1;
    logic [dpb_pkg::CHAN_W-1:0]        out_chan2;
    logic                              frame_last;

    modport source (output valid, x_pos, y_pos, z_pos, point_valid, out_chan0, out_chan1,
                    out_chan2, frame_last, input ready);
    modport sink   (input valid, x_pos, y_pos, z_pos, point_valid, out_chan0, out_chan1,
                    out_chan2, frame_last, output ready);
endinterface

// ===== design/dpb_cfg_if.sv =====
`timescale 1ns / 1ps
// Configuration write channel: valid/ready handshake with register index and data.
// Depends on dpb_pkg for field widths.
interface dpb_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [dpb_pkg::CFG_IDX_W-1:0]   index;
    logic [dpb_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/dpb_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer for one pixel: accept, offset multiply, focal multiply, deliver.
// Depends on dpb_pkg for the state, command and status types.
module dpb_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  dpb_pkg::dp_status_t  status,
    output dpb_pkg::dp_cmd_t     cmd
);

    dpb_pkg::state_t state_reg;
    dpb_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= dpb_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            dpb_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = dpb_pkg::ST_MULT_OFFSET;
                end
            end
            dpb_pkg::ST_MULT_OFFSET:
            begin
                cmd.step_offset = 1'b1;
                state_next      = dpb_pkg::ST_MULT_FOCAL;
            end
            dpb_pkg::ST_MULT_FOCAL:
            begin
                cmd.step_focal = 1'b1;
                state_next     = dpb_pkg::ST_DELIVER;
            end
            dpb_pkg::ST_DELIVER:
            begin
                // hold until the output register can take the point
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = dpb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dpb_pkg::ST_IDLE;
            end
        endcase
    end

    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.accept, cmd.step_offset, cmd.step_focal, cmd.load_out}))
        else $error("more than one datapath command in a cycle");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> status.out_free)
        else $error("output load while output register is occupied");

    a_accept_then_mult: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> cmd.step_offset ##1 cmd.step_focal)
        else $error("multiply steps did not follow a transfer");

endmodule

// ===== design/dpb_datapath.sv =====
`timescale 1ns / 1ps
// Datapath: config registers, centred pixel counters, two-step projection multiply
// and the output register. Depends on dpb_pkg; driven by dpb_ctrl commands.
module dpb_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [dpb_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [dpb_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  dpb_pkg::pixel_t                      pixel_in,
    input  dpb_pkg::dp_cmd_t                     cmd,
    output dpb_pkg::dp_status_t                  status,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output dpb_pkg::point_t                      point_out
);

    localparam int HW  = dpb_pkg::HALF_W;
    localparam int OW  = dpb_pkg::OFS_W;
    localparam int PDW = dpb_pkg::PD_W;
    localparam int PFW = dpb_pkg::PF_W;
    localparam int QW  = dpb_pkg::Q_W;
    localparam int PW  = dpb_pkg::POS_W;

    // configuration
    logic [HW-1:0]               half_width_reg;
    logic [HW-1:0]               half_height_reg;
    logic [dpb_pkg::FOCAL_W-1:0] inv_focal_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_width_reg  <= dpb_pkg::HALF_W_RESET;
            half_height_reg <= dpb_pkg::HALF_H_RESET;
            inv_focal_reg   <= dpb_pkg::FOCAL_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                dpb_pkg::CFG_HALF_WIDTH:  half_width_reg  <= cfg_data[HW-1:0];
                dpb_pkg::CFG_HALF_HEIGHT: half_height_reg <= cfg_data[HW-1:0];
                dpb_pkg::CFG_INV_FOCAL:   inv_focal_reg   <= cfg_data[dpb_pkg::FOCAL_W-1:0];
                default: ;
            endcase
        end
    end

    // counters and offsets
    logic [HW-1:0] column_reg, column_next;
    logic [HW-1:0] row_reg, row_next;
    logic [HW-1:0] hw_eff, hh_eff;
    logic          last_col, last_row;
    logic signed [OW-1:0] u_ofs, v_ofs;

    always_comb
    begin
        hw_eff   = dpb_pkg::eff_half(half_width_reg);
        hh_eff   = dpb_pkg::eff_half(half_height_reg);
        last_col = {1'b0, column_reg} >= ({hw_eff, 1'b0} - OW'(1));
        last_row = {1'b0, row_reg} >= ({hh_eff, 1'b0} - OW'(1));
        u_ofs    = $signed({1'b0, column_reg}) - $signed({1'b0, hw_eff});
        v_ofs    = $signed({1'b0, row_reg}) - $signed({1'b0, hh_eff});
        column_next = column_reg;
        row_next    = row_reg;
        if (cmd.accept)
        begin
            if (last_col)
            begin
                column_next = '0;
                row_next    = last_row ? '0 : row_reg + HW'(1);
            end
            else
            begin
                column_next = column_reg + HW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg <= '0;
            row_reg    <= '0;
        end
        else
        begin
            column_reg <= column_next;
            row_reg    <= row_next;
        end
    end

    // captured pixel; offsets split into sign and magnitude
    logic [dpb_pkg::DEPTH_W-1:0] depth_reg;
    logic [dpb_pkg::CHAN_W-1:0]  c0_reg, c1_reg, c2_reg;
    logic                        last_reg;
    logic                        u_neg_reg, v_neg_reg;
    logic [HW-1:0]               u_mag_reg, v_mag_reg;
    logic [OW-1:0]               u_abs, v_abs;
    logic [PDW-1:0]              u_pd_reg, v_pd_reg;
    logic [PFW-1:0]              u_pf_reg, v_pf_reg;

    assign u_abs = u_ofs[OW-1] ? OW'(-u_ofs) : OW'(u_ofs);
    assign v_abs = v_ofs[OW-1] ? OW'(-v_ofs) : OW'(v_ofs);

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            depth_reg <= pixel_in.depth_mm;
            c0_reg    <= pixel_in.chan0;
            c1_reg    <= pixel_in.chan1;
            c2_reg    <= pixel_in.chan2;
            last_reg  <= last_col && last_row;
            u_neg_reg <= u_ofs[OW-1];
            v_neg_reg <= v_ofs[OW-1];
            u_mag_reg <= u_abs[HW-1:0];
            v_mag_reg <= v_abs[HW-1:0];
        end
        if (cmd.step_offset)
        begin
            u_pd_reg <= PDW'(u_mag_reg) * PDW'(depth_reg);
            v_pd_reg <= PDW'(v_mag_reg) * PDW'(depth_reg);
        end
        if (cmd.step_focal)
        begin
            u_pf_reg <= PFW'(u_pd_reg) * PFW'(inv_focal_reg);
            v_pf_reg <= PFW'(v_pd_reg) * PFW'(inv_focal_reg);
        end
    end

    // final sign and output register
    logic [QW-1:0]          u_q, v_q;
    logic signed [PW-1:0]   x_val, y_val;
    logic                   depth_nz;
    logic                   out_valid_reg, out_valid_next;
    dpb_pkg::point_t        point_reg;

    always_comb
    begin
        u_q      = u_pf_reg[PFW-1:dpb_pkg::FRAC_SHIFT];
        v_q      = v_pf_reg[PFW-1:dpb_pkg::FRAC_SHIFT];
        depth_nz = depth_reg != '0;
        // negate after the shift so rounding goes toward zero
        x_val = u_neg_reg ? -$signed(PW'(u_q)) : $signed(PW'(u_q));
        y_val = v_neg_reg ? -$signed(PW'(v_q)) : $signed(PW'(v_q));
        if (!depth_nz)
        begin
            x_val = '0;
            y_val = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            point_reg.x_pos       <= x_val;
            point_reg.y_pos       <= y_val;
            point_reg.z_pos       <= depth_nz ? {depth_reg, 8'h00} : '0;
            point_reg.point_valid <= depth_nz;
            point_reg.out_chan0   <= c0_reg;
            point_reg.out_chan1   <= c1_reg;
            point_reg.out_chan2   <= c2_reg;
            point_reg.frame_last  <= last_reg;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    assign out_valid       = out_valid_reg;
    assign point_out       = point_reg;
    assign status.out_free = !out_valid_reg || out_ready;

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> out_valid_reg)
        else $error("output valid not raised after load");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !point_reg.point_valid |->
            point_reg.x_pos == '0 && point_reg.y_pos == '0 && point_reg.z_pos == '0)
        else $error("invalid point carries nonzero coordinates");

    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept && last_col && last_row |=> column_reg == '0 && row_reg == '0)
        else $error("counters did not wrap at end of frame");

endmodule

// ===== design/depth_to_point_backprojection_core.sv =====
`timescale 1ns / 1ps
// Top level of the depth-to-point back-projection block.
// Depends on dpb_pkg, the three channel interfaces, dpb_ctrl and dpb_datapath.
//
// Usage:
//   pixel : raster-ordered pixels (depth_mm, chan0..chan2), valid/ready.
//   point : one back-projected point per pixel (x_pos, y_pos, z_pos, point_valid,
//           colour bytes, frame_last), valid/ready.
//   cfg   : register writes (index 0 half_width, 1 half_height, 2 inv_focal);
//           always ready, write only while no pixel is in flight.
// Timing: a pixel transfer is followed by the offset multiply and the focal
//   multiply, and the point is loaded into the output register in the deliver
//   state once that register is free; the point is valid in the cycle after the load.
//   One pixel is in work at a time: the idle state that takes the transfer,
//   the two multiply steps and the deliver state.
// Reset: counters return to the first column and row, registers to 320, 240
//   and 31956, no point is pending.
// Stall: the output register holds a point until it is taken; the next pixel is
//   still accepted and computed, then waits for the output register to free up.
module depth_to_point_backprojection_core (
    input  logic        clk,
    input  logic        rst_n,
    dpb_pixel_if.sink   pixel,
    dpb_point_if.source point,
    dpb_cfg_if.sink     cfg
);

    dpb_pkg::dp_cmd_t    cmd;
    dpb_pkg::dp_status_t status;
    dpb_pkg::pixel_t     pixel_in;
    dpb_pkg::point_t     point_out;

    assign cfg.ready = 1'b1;

    assign pixel_in.depth_mm = pixel.depth_mm;
    assign pixel_in.chan0    = pixel.chan0;
    assign pixel_in.chan1    = pixel.chan1;
    assign pixel_in.chan2    = pixel.chan2;

    dpb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pixel.valid),
        .in_ready (pixel.ready),
        .status   (status),
        .cmd      (cmd)
    );

    dpb_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg.valid),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .pixel_in  (pixel_in),
        .cmd       (cmd),
        .status    (status),
        .out_valid (point.valid),
        .out_ready (point.ready),
        .point_out (point_out)
    );

    assign point.x_pos       = point_out.x_pos;
    assign point.y_pos       = point_out.y_pos;
    assign point.z_pos       = point_out.z_pos;
    assign point.point_valid = point_out.point_valid;
    assign point.out_chan0   = point_out.out_chan0;
    assign point.out_chan1   = point_out.out_chan1;
    assign point.out_chan2   = point_out.out_chan2;
    assign point.frame_last  = point_out.frame_last;

endmodule
